// ===== hw/rtl/tep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tep_pkg
// Shared types and constants of the timed event pool.
// ----------------------------------------------------------------------------
package tep_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = 4;
  localparam int TIME_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int OP_W       = 3;

  // operation codes carried on the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_ARM_ONCE  = 3'd1,
    OP_ARM_RELD  = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_ARM_DELTA = 3'd4
  } op_t;

  // contents of one slot cell
  typedef struct packed {
    logic                  armed;
    logic [TIME_WIDTH-1:0] due;
    logic [TIME_WIDTH-1:0] period;
    logic [VALUE_W-1:0]    value;
  } cell_t;

  // write command broadcast to the cells
  typedef struct packed {
    logic                  clear;
    logic                  set_period;
    logic [TIME_WIDTH-1:0] due;
    logic [TIME_WIDTH-1:0] period;
    logic [VALUE_W-1:0]    value;
  } wr_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tep_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tep_cell
// One slot cell of the ring: holds a slot, takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module tep_cell
  import tep_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    shift_en,
  input  wire cell_t   nb_in,
  input  wire logic    wr_en,
  input  wire wr_cmd_t wr_cmd,
  output cell_t        cell_q
);

  cell_t cell_r;
  cell_t cell_nxt;

  // shift during a scan, direct write while idle
  always_comb begin
    cell_nxt = cell_r;
    if (shift_en) begin
      cell_nxt = nb_in;
    end else if (wr_en) begin
      if (wr_cmd.clear) begin
        cell_nxt.armed  = 1'b0;
        cell_nxt.due    = '0;
        cell_nxt.period = '0;
      end else begin
        cell_nxt.armed = 1'b1;
        cell_nxt.due   = wr_cmd.due;
        cell_nxt.value = wr_cmd.value;
        if (wr_cmd.set_period) begin
          cell_nxt.period = wr_cmd.period;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_q = cell_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tep_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tep_eval
// Head of the ring: due test and reload of the slot in cell zero.
// ----------------------------------------------------------------------------
module tep_eval
  import tep_pkg::*;
(
  input  wire cell_t                 head,
  input  wire logic [TIME_WIDTH-1:0] now,
  output logic                       fire,
  output cell_t                      updated
);

  logic [TIME_WIDTH-1:0] diff;

  // due when now - due reads as non-negative
  always_comb begin
    diff    = now - head.due;
    fire    = head.armed && !diff[TIME_WIDTH-1];
    updated = head;
    if (fire) begin
      if (head.period != '0) begin
        updated.due = head.due + head.period;
      end else begin
        updated.armed = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/timed_event_pool_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_pool_core
// Pool of timed event slots held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Arm and clear write their slot cell on transfer; the pool stays idle and accepts the
// next item in the cycle after. A tick turns the whole ring through the head, one slot
// each cycle unless the result side stalls, and then enters a flush state that waits
// while the result side stalls. A result waits as pending until the next firing slot is
// found, then moves to the output register; a tick's final one moves there in flush.
// Synchronous active-low reset clears all slots, the current time and the control.
module timed_event_pool_core
  import tep_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,  // slot, when, period, user_value, now, zero pad
  input  wire logic [2:0]   in_tuser,  // op
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [71:0]       out_tdata, // fired_slot, fired_value, scheduled_time, zero pad
  output logic              out_tlast  // last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [TIME_WIDTH-1:0] cur_time_r, cur_time_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]     pend_slot_r, pend_slot_nxt;
  logic [VALUE_W-1:0]    pend_value_r, pend_value_nxt;
  logic [TIME_WIDTH-1:0] pend_time_r, pend_time_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic [TIME_WIDTH-1:0] out_time_r, out_time_nxt;
  logic                  out_last_r, out_last_nxt;

  // input fields
  logic [SLOT_W-1:0]     in_slot;
  logic [TIME_WIDTH-1:0] in_when, in_period, in_now;
  logic [VALUE_W-1:0]    in_value;
  op_t                   in_op;
  logic                  in_xfer;

  assign in_slot   = in_tdata[3:0];
  assign in_when   = in_tdata[35:4];
  assign in_period = in_tdata[67:36];
  assign in_value  = in_tdata[99:68];
  assign in_now    = in_tdata[131:100];
  assign in_op     = op_t'(in_tuser);
  assign in_xfer   = in_tvalid && in_tready;

  // ring of slot cells
  cell_t             cell_q [SLOTS];
  cell_t             head_upd;
  logic              head_fire;
  logic              shift_en;
  logic              stall;
  logic              out_free;
  logic              wr_any;
  logic [SLOTS-1:0]  wr_en;
  wr_cmd_t           wr_cmd;

  tep_eval u_eval (
    .head    (cell_q[0]),
    .now     (cur_time_r),
    .fire    (head_fire),
    .updated (head_upd)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    cell_t nb;
    if (i == SLOTS - 1) begin : g_tail
      assign nb = head_upd;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    assign wr_en[i] = wr_any && (in_slot == SLOT_W'(i));
    tep_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .nb_in    (nb),
      .wr_en    (wr_en[i]),
      .wr_cmd   (wr_cmd),
      .cell_q   (cell_q[i])
    );
  end

  // write command from an arm or clear transfer
  always_comb begin
    wr_any            = 1'b0;
    wr_cmd.clear      = 1'b0;
    wr_cmd.set_period = 1'b0;
    wr_cmd.due        = in_when;
    wr_cmd.period     = in_period;
    wr_cmd.value      = in_value;
    case (in_op)
      OP_ARM_ONCE: begin
        wr_any = in_xfer;
      end
      OP_ARM_RELD: begin
        wr_any            = in_xfer;
        wr_cmd.set_period = 1'b1;
      end
      OP_CLEAR: begin
        wr_any       = in_xfer;
        wr_cmd.clear = 1'b1;
      end
      OP_ARM_DELTA: begin
        wr_any     = in_xfer;
        wr_cmd.due = cur_time_r + in_when;
      end
      default: begin
        wr_any = 1'b0;
      end
    endcase
  end

  assign out_free  = !out_v_r || out_tready;
  assign stall     = (state_r == ST_SCAN) && head_fire && pend_v_r && !out_free;
  assign shift_en  = (state_r == ST_SCAN) && !stall;
  assign in_tready = (state_r == ST_IDLE);

  // scan control, pending result and output register
  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    cur_time_nxt   = cur_time_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    pend_value_nxt = pend_value_r;
    pend_time_nxt  = pend_time_r;
    out_v_nxt      = out_v_r && !out_tready;
    out_slot_nxt   = out_slot_r;
    out_value_nxt  = out_value_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_op == OP_TICK) begin
          cur_time_nxt = in_now;
          scan_cnt_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (head_fire) begin
            // older pending result is not the last one
            if (pend_v_r) begin
              out_v_nxt     = 1'b1;
              out_slot_nxt  = pend_slot_r;
              out_value_nxt = pend_value_r;
              out_time_nxt  = pend_time_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt     = 1'b1;
            pend_slot_nxt  = scan_cnt_r;
            pend_value_nxt = cell_q[0].value;
            pend_time_nxt  = cell_q[0].due;
          end
          if (scan_cnt_r == SLOT_W'(SLOTS - 1)) begin
            scan_cnt_nxt = '0;
            state_nxt    = ST_FLUSH;
          end else begin
            scan_cnt_nxt = scan_cnt_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt     = 1'b1;
          out_slot_nxt  = pend_slot_r;
          out_value_nxt = pend_value_r;
          out_time_nxt  = pend_time_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
      cur_time_r <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      cur_time_r <= cur_time_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r  <= pend_slot_nxt;
    pend_value_r <= pend_value_nxt;
    pend_time_r  <= pend_time_nxt;
    out_slot_r   <= out_slot_nxt;
    out_value_r  <= out_value_nxt;
    out_time_r   <= out_time_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, out_time_r, out_value_r, out_slot_r};

`ifndef SYNTHESIS
  // no result may be left pending between ticks
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_v_r)
    else $error("pending result left outside a tick");

  // scan counter rests at zero outside the scan
  a_cnt_rest: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_SCAN |-> scan_cnt_r == '0)
    else $error("scan counter not at rest");

  // a stalled scan keeps its position in the ring
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> scan_cnt_r == $past(scan_cnt_r) && state_r == ST_SCAN)
    else $error("scan moved while stalled");

  // a tick transfer starts a scan
  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_op == OP_TICK |=> state_r == ST_SCAN)
    else $error("tick did not start a scan");
`endif

endmodule
`default_nettype wire
